// ===== rtl/core/go_to_goal_p_controller_defines.svh =====
`ifndef GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define G2G_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define G2G_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/g2g_pkg.sv =====
package g2g_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 12;
  localparam int GUARD        = 8;
  localparam int TABLE_LEN    = 24;
  localparam int IDX_W        = $clog2(TABLE_LEN);

  localparam int POS_W      = 16;
  localparam int HEAD_W     = 15;
  localparam int GAIN_W     = 12;
  localparam int LIN_W      = 18;
  localparam int ANG_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int DIFF_W  = POS_W + 1;
  localparam int VEC_W   = DIFF_W + GUARD + 3;
  localparam int ANGLE_W = 34;
  localparam int BEAR_W  = FRAC_BITS + 4;
  localparam int ERR_W   = ((BEAR_W > HEAD_W) ? BEAR_W : HEAD_W) + 1;
  localparam int DIST_W  = LIN_W;

  // magnitude scale 1/K in Q16
  localparam int KINV    = 39797;
  localparam int MUL_A_W = VEC_W;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int DIST_SH  = 16 + GUARD;
  localparam int BEAR_SH  = 30 - FRAC_BITS;
  localparam int SPEED_SH = 8;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = ANGLE_W'(64'sd1686629713);

  localparam int LIN_MAX = 262143;
  localparam int ANG_MAX = 524287;
  localparam int ANG_MIN = -524288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_TOL,
    REG_LIN_GAIN,
    REG_ANG_GAIN
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_DIST,
    S_RND,
    S_LIN,
    S_ANG,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MUL_DIST,
    MUL_LIN,
    MUL_ANG
  } mul_sel_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/g2g_if.sv =====
interface g2g_pose_if;
  logic                               valid;
  logic                               ready;
  logic [g2g_pkg::POS_W-1:0]          pose_x;
  logic [g2g_pkg::POS_W-1:0]          pose_y;
  logic signed [g2g_pkg::HEAD_W-1:0]  pose_heading;

  modport source (output valid, output pose_x, output pose_y, output pose_heading,
                  input ready);
  modport sink (input valid, input pose_x, input pose_y, input pose_heading,
                output ready);
endinterface

interface g2g_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [g2g_pkg::LIN_W-1:0]         linear_speed;
  logic signed [g2g_pkg::ANG_W-1:0]  turn_rate;
  logic                              arrived;

  modport source (output valid, output linear_speed, output turn_rate,
                  output arrived, input ready);
  modport sink (input valid, input linear_speed, input turn_rate,
                input arrived, output ready);
endinterface

// ===== rtl/core/go_to_goal_p_controller.sv =====
// go-to-goal proportional controller, one pose request in, one drive command out
// steps: pose accept, cordic loop, then DIST, RND, LIN, ANG and FIN to command valid
// one pose in flight at a time, new poses taken only in IDLE, set by the shared cordic
//   micro-rotation loop and the single multiplier used three times per pose
// reset: synchronous active-low rst_n; goal/tolerance/gains take their defaults,
//   first-pose and arrived flags clear, no command pending
`include "go_to_goal_p_controller_defines.svh"

module go_to_goal_p_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [g2g_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [g2g_pkg::CFG_DATA_W-1:0]       cfg_data,
  g2g_pose_if.sink                             in_pose,
  g2g_cmd_if.source                            out_cmd
);

  // configuration registers
  logic [g2g_pkg::POS_W-1:0]  goal_x_r;
  logic [g2g_pkg::POS_W-1:0]  goal_y_r;
  logic [g2g_pkg::POS_W-1:0]  tol_r;
  logic [g2g_pkg::GAIN_W-1:0] lin_gain_r;
  logic [g2g_pkg::GAIN_W-1:0] ang_gain_r;

  // sequencer
  g2g_pkg::state_t            state_r, state_nxt;
  logic [g2g_pkg::IDX_W-1:0]  step_r;
  logic                       seen_first_r;
  logic                       arrived_latch_r;

  // control decoded from the state
  logic                       in_ready;
  logic                       load_en;
  logic                       step_en;
  logic                       prod_en;
  logic                       fin_st;
  g2g_pkg::mul_sel_t          mul_sel;

  // cordic vector and angle accumulator
  logic signed [g2g_pkg::VEC_W-1:0]   x_r, y_r;
  logic signed [g2g_pkg::ANGLE_W-1:0] z_r;
  logic                               zero_r;
  logic signed [g2g_pkg::HEAD_W-1:0]  hd_r;

  // post-processing registers
  logic signed [g2g_pkg::PROD_W-1:0]  prod_r;
  logic [g2g_pkg::DIST_W-1:0]         dist_r;
  logic signed [g2g_pkg::BEAR_W-1:0]  bear_r;
  logic [g2g_pkg::LIN_W-1:0]          lin_r;

  // output register, parts the two handshake sides
  logic                               out_valid_r;
  logic [g2g_pkg::LIN_W-1:0]          out_lin_r;
  logic signed [g2g_pkg::ANG_W-1:0]   out_ang_r;
  logic                               out_arr_r;

  logic in_req;
  logic out_free;
  assign in_req   = in_pose.valid && in_ready;
  assign out_free = !out_valid_r || out_cmd.ready;

  // ------------------------------------------------------------------
  // configuration writes, unknown indexes are dropped
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= g2g_pkg::POS_W'(4096);
      goal_y_r   <= g2g_pkg::POS_W'(4096);
      tol_r      <= g2g_pkg::POS_W'(41);
      lin_gain_r <= g2g_pkg::GAIN_W'(384);
      ang_gain_r <= g2g_pkg::GAIN_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        g2g_pkg::REG_GOAL_X:   goal_x_r   <= cfg_data[g2g_pkg::POS_W-1:0];
        g2g_pkg::REG_GOAL_Y:   goal_y_r   <= cfg_data[g2g_pkg::POS_W-1:0];
        g2g_pkg::REG_TOL:      tol_r      <= cfg_data[g2g_pkg::POS_W-1:0];
        g2g_pkg::REG_LIN_GAIN: lin_gain_r <= cfg_data[g2g_pkg::GAIN_W-1:0];
        g2g_pkg::REG_ANG_GAIN: ang_gain_r <= cfg_data[g2g_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      g2g_pkg::S_IDLE: begin
        if (in_pose.valid) state_nxt = g2g_pkg::S_CORDIC;
      end
      g2g_pkg::S_CORDIC: begin
        if (step_r == g2g_pkg::IDX_W'(g2g_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = g2g_pkg::S_DIST;
        end
      end
      g2g_pkg::S_DIST: state_nxt = g2g_pkg::S_RND;
      g2g_pkg::S_RND:  state_nxt = g2g_pkg::S_LIN;
      g2g_pkg::S_LIN:  state_nxt = g2g_pkg::S_ANG;
      g2g_pkg::S_ANG:  state_nxt = g2g_pkg::S_FIN;
      // hold the finished command until the output register frees up
      g2g_pkg::S_FIN: begin
        if (out_free) state_nxt = g2g_pkg::S_IDLE;
      end
      default: state_nxt = g2g_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // control outputs of the sequencer
  // ------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    prod_en  = 1'b0;
    fin_st   = 1'b0;
    mul_sel  = g2g_pkg::MUL_DIST;
    case (state_r)
      g2g_pkg::S_IDLE:   in_ready = 1'b1;
      g2g_pkg::S_CORDIC: step_en  = 1'b1;
      g2g_pkg::S_DIST: begin
        prod_en = 1'b1;
        mul_sel = g2g_pkg::MUL_DIST;
      end
      g2g_pkg::S_RND: ;
      g2g_pkg::S_LIN: begin
        prod_en = 1'b1;
        mul_sel = g2g_pkg::MUL_LIN;
      end
      g2g_pkg::S_ANG: begin
        prod_en = 1'b1;
        mul_sel = g2g_pkg::MUL_ANG;
      end
      g2g_pkg::S_FIN: fin_st = 1'b1;
      default: ;
    endcase
  end

  assign load_en = in_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= g2g_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------------
  // pose load: goal offset, guard bits, quadrant pre-rotation
  // ------------------------------------------------------------------
  logic signed [g2g_pkg::DIFF_W-1:0]  dx, dy;
  logic signed [g2g_pkg::VEC_W-1:0]   x0, y0;
  logic signed [g2g_pkg::VEC_W-1:0]   x_ld, y_ld;
  logic signed [g2g_pkg::ANGLE_W-1:0] z_ld;

  assign dx = $signed({1'b0, goal_x_r}) - $signed({1'b0, in_pose.pose_x});
  assign dy = $signed({1'b0, goal_y_r}) - $signed({1'b0, in_pose.pose_y});
  assign x0 = {{(g2g_pkg::VEC_W - g2g_pkg::DIFF_W - g2g_pkg::GUARD){dx[g2g_pkg::DIFF_W-1]}},
               dx, {g2g_pkg::GUARD{1'b0}}};
  assign y0 = {{(g2g_pkg::VEC_W - g2g_pkg::DIFF_W - g2g_pkg::GUARD){dy[g2g_pkg::DIFF_W-1]}},
               dy, {g2g_pkg::GUARD{1'b0}}};

  always_comb begin
    x_ld = x0;
    y_ld = y0;
    z_ld = '0;
    // left half plane: turn by a quarter so the loop converges
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x_ld = y0;
        y_ld = -x0;
        z_ld = g2g_pkg::HALF_PI_Q30;
      end else begin
        x_ld = -y0;
        y_ld = x0;
        z_ld = -g2g_pkg::HALF_PI_Q30;
      end
    end
  end

  // ------------------------------------------------------------------
  // shared micro-rotation unit, one step per cycle
  // ------------------------------------------------------------------
  logic signed [g2g_pkg::VEC_W-1:0]   x_sh, y_sh;
  logic signed [g2g_pkg::ANGLE_W-1:0] atan_v;
  logic signed [g2g_pkg::VEC_W-1:0]   x_rot, y_rot;
  logic signed [g2g_pkg::ANGLE_W-1:0] z_rot;

  assign x_sh   = x_r >>> step_r;
  assign y_sh   = y_r >>> step_r;
  assign atan_v = $signed({{(g2g_pkg::ANGLE_W - 32){1'b0}}, g2g_pkg::atan_q30(step_r)});

  always_comb begin
    if (!y_r[g2g_pkg::VEC_W-1]) begin
      x_rot = x_r + y_sh;
      y_rot = y_r - x_sh;
      z_rot = z_r + atan_v;
    end else begin
      x_rot = x_r - y_sh;
      y_rot = y_r + x_sh;
      z_rot = z_r - atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (load_en) begin
      step_r <= '0;
    end else if (step_en) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      x_r    <= x_ld;
      y_r    <= y_ld;
      z_r    <= z_ld;
      zero_r <= (dx == '0) && (dy == '0);
      hd_r   <= in_pose.pose_heading;
    end else if (step_en) begin
      x_r <= x_rot;
      y_r <= y_rot;
      z_r <= z_rot;
    end
  end

  // ------------------------------------------------------------------
  // shared multiplier: gain correction, linear gain, angular gain
  // ------------------------------------------------------------------
  logic signed [g2g_pkg::MUL_A_W-1:0] mul_a;
  logic signed [g2g_pkg::MUL_B_W-1:0] mul_b;
  logic signed [g2g_pkg::PROD_W-1:0]  mul_p;
  logic signed [g2g_pkg::ERR_W-1:0]   head_err;

  assign head_err = g2g_pkg::ERR_W'(bear_r) - g2g_pkg::ERR_W'(hd_r);

  always_comb begin
    case (mul_sel)
      g2g_pkg::MUL_DIST: begin
        // negative magnitude after the loop clamps to zero
        mul_a = x_r[g2g_pkg::VEC_W-1] ? '0 : x_r;
        mul_b = g2g_pkg::MUL_B_W'(g2g_pkg::KINV);
      end
      g2g_pkg::MUL_LIN: begin
        mul_a = $signed({{(g2g_pkg::MUL_A_W - g2g_pkg::DIST_W){1'b0}}, dist_r});
        mul_b = $signed({{(g2g_pkg::MUL_B_W - g2g_pkg::GAIN_W){1'b0}}, lin_gain_r});
      end
      g2g_pkg::MUL_ANG: begin
        mul_a = g2g_pkg::MUL_A_W'(head_err);
        mul_b = $signed({{(g2g_pkg::MUL_B_W - g2g_pkg::GAIN_W){1'b0}}, ang_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (prod_en) prod_r <= mul_p;
  end

  // ------------------------------------------------------------------
  // rounding and saturation
  // ------------------------------------------------------------------
  logic signed [g2g_pkg::ANGLE_W-1:0] bear_sum;
  logic signed [g2g_pkg::PROD_W-1:0]  dist_sum;
  logic signed [g2g_pkg::PROD_W-1:0]  spd_sum;
  logic signed [g2g_pkg::PROD_W-g2g_pkg::SPEED_SH-1:0] spd_full;
  logic [g2g_pkg::LIN_W-1:0]          lin_sat;
  logic signed [g2g_pkg::ANG_W-1:0]   ang_sat;

  // round half up, then floor shift
  assign bear_sum = z_r + g2g_pkg::ANGLE_W'(64'sd1 <<< (g2g_pkg::BEAR_SH - 1));
  assign dist_sum = prod_r + g2g_pkg::PROD_W'(64'sd1 <<< (g2g_pkg::DIST_SH - 1));
  assign spd_sum  = prod_r + g2g_pkg::PROD_W'(64'sd1 <<< (g2g_pkg::SPEED_SH - 1));
  assign spd_full = spd_sum[g2g_pkg::PROD_W-1:g2g_pkg::SPEED_SH];

  always_comb begin
    if (spd_full < 0) begin
      lin_sat = '0;
    end else if (spd_full > (g2g_pkg::PROD_W - g2g_pkg::SPEED_SH)'(g2g_pkg::LIN_MAX)) begin
      lin_sat = g2g_pkg::LIN_W'(g2g_pkg::LIN_MAX);
    end else begin
      lin_sat = spd_full[g2g_pkg::LIN_W-1:0];
    end
  end

  always_comb begin
    if (spd_full > (g2g_pkg::PROD_W - g2g_pkg::SPEED_SH)'(g2g_pkg::ANG_MAX)) begin
      ang_sat = g2g_pkg::ANG_W'(g2g_pkg::ANG_MAX);
    end else if (spd_full < (g2g_pkg::PROD_W - g2g_pkg::SPEED_SH)'(g2g_pkg::ANG_MIN)) begin
      ang_sat = g2g_pkg::ANG_W'(g2g_pkg::ANG_MIN);
    end else begin
      ang_sat = spd_full[g2g_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    // bearing of a zero offset is taken as zero
    if (state_r == g2g_pkg::S_DIST) begin
      bear_r <= zero_r ? '0 : bear_sum[g2g_pkg::BEAR_SH +: g2g_pkg::BEAR_W];
    end
    if (state_r == g2g_pkg::S_RND) begin
      dist_r <= dist_sum[g2g_pkg::DIST_SH +: g2g_pkg::DIST_W];
    end
    if (state_r == g2g_pkg::S_ANG) begin
      lin_r <= lin_sat;
    end
  end

  // ------------------------------------------------------------------
  // arrival decision and command register
  // ------------------------------------------------------------------
  logic is_first;
  logic near_goal;
  logic arrived_latch_nxt;
  logic zero_cmd;

  assign is_first          = !seen_first_r;
  assign near_goal         = dist_r <= g2g_pkg::DIST_W'(tol_r);
  // the very first pose never sets arrived
  assign arrived_latch_nxt = arrived_latch_r || (!is_first && near_goal);
  assign zero_cmd          = !is_first && arrived_latch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r    <= 1'b0;
      arrived_latch_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (fin_st && out_free) begin
        seen_first_r    <= 1'b1;
        arrived_latch_r <= arrived_latch_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_cmd.ready) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_st && out_free) begin
      out_lin_r <= zero_cmd ? '0 : lin_r;
      out_ang_r <= zero_cmd ? '0 : ang_sat;
      out_arr_r <= zero_cmd;
    end
  end

  assign in_pose.ready         = in_ready;
  assign out_cmd.valid         = out_valid_r;
  assign out_cmd.linear_speed  = out_lin_r;
  assign out_cmd.turn_rate     = out_ang_r;
  assign out_cmd.arrived       = out_arr_r;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `G2G_ASSERT_NEXT(a_busy_after_req, in_req, !in_pose.ready, "pose taken while busy")
  `G2G_ASSERT_NOW(a_arrived_zero, out_cmd.valid && out_cmd.arrived, (out_cmd.linear_speed == '0) && (out_cmd.turn_rate == '0), "arrived with nonzero command")
  `G2G_ASSERT_NEXT(a_latch_holds, arrived_latch_r, arrived_latch_r, "arrived latch dropped")
  `G2G_ASSERT_NOW(a_step_range, state_r == g2g_pkg::S_CORDIC, step_r <= g2g_pkg::IDX_W'(g2g_pkg::CORDIC_STEPS - 1), "cordic step out of range")

endmodule

// ===== tb/go_to_goal_p_controller_tb.sv =====
`timescale 1ns / 100ps

module go_to_goal_p_controller_tb;
  import g2g_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int END_WAIT        = 30;      // a little over the pose-to-command latency
  localparam int MAX_REPORTS     = 50;
  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int HEAD_LIM        = 12868;   // pi in Q3.12
  localparam int POS_LIM         = 45056;
  localparam longint HALF_PI_SCALED = 1686629713;  // pi/2 in Q30

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // one pending pose request, drain asks the driver to wait for an empty pipe first
  typedef struct {
    logic [POS_W-1:0]         x;
    logic [POS_W-1:0]         y;
    logic signed [HEAD_W-1:0] heading;
    bit                       drain;
  } pose_req_t;

  typedef struct {
    logic [LIN_W-1:0]        lin;
    logic signed [ANG_W-1:0] ang;
    logic                    arrived;
  } drive_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  g2g_pose_if pose_bus ();
  g2g_cmd_if  cmd_bus ();

  go_to_goal_p_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pose   (pose_bus),
    .out_cmd   (cmd_bus)
  );

  // poses waiting to be driven and commands waiting to come out
  pose_req_t  pose_q[$];
  drive_cmd_t cmd_exp_q[$];
  pose_req_t  next_pose;
  drive_cmd_t want_cmd;

  // shadow of the controller's registers and flags
  logic [POS_W-1:0]  goal_x_m;
  logic [POS_W-1:0]  goal_y_m;
  logic [POS_W-1:0]  tol_m;
  logic [GAIN_W-1:0] lin_gain_m;
  logic [GAIN_W-1:0] ang_gain_m;
  bit                seen_first_m;
  bit                arrived_m;

  // floor(atan(2^-i) * 2^30) for the vectoring rotations
  longint atan_tbl [TABLE_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int poses_sent;
  int cmds_checked;
  int arrivals;
  int settings_applied;
  int cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected drive command for one pose, advances the first-pose and arrival flags
  function automatic drive_cmd_t predict_command(input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py,
                                                 input logic signed [HEAD_W-1:0] hd);
    longint dx, dy, vx, vy, vz, nx, ny, dist_v, bearing, lin, ang;
    bit is_first;
    drive_cmd_t r;
    dx = longint'(goal_x_m) - longint'(px);
    dy = longint'(goal_y_m) - longint'(py);
    if (dx == 0 && dy == 0) begin
      // pose on the goal: no bearing to speak of
      dist_v  = 0;
      bearing = 0;
    end else begin
      vx = dx * (longint'(1) << GUARD);
      vy = dy * (longint'(1) << GUARD);
      vz = 0;
      // left half plane: rotate by a quarter turn first, goal straight behind lands on +pi
      if (vx < 0) begin
        if (vy >= 0) begin
          nx = vy;
          ny = -vx;
          vz = HALF_PI_SCALED;
        end else begin
          nx = -vy;
          ny = vx;
          vz = -HALF_PI_SCALED;
        end
        vx = nx;
        vy = ny;
      end
      for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
        if (vy >= 0) begin
          nx = vx + (vy >>> i);
          ny = vy - (vx >>> i);
          vz = vz + atan_tbl[i];
        end else begin
          nx = vx - (vy >>> i);
          ny = vy + (vx >>> i);
          vz = vz - atan_tbl[i];
        end
        vx = nx;
        vy = ny;
      end
      if (vx < 0) vx = 0;
      dist_v  = (vx * KINV + (longint'(1) << (DIST_SH - 1))) >>> DIST_SH;
      bearing = (vz + (longint'(1) << (BEAR_SH - 1))) >>> BEAR_SH;
    end

    // the very first pose always gets a command, arrival latches until reset
    is_first     = !seen_first_m;
    seen_first_m = 1'b1;
    if (!is_first && !arrived_m && dist_v <= longint'(tol_m)) arrived_m = 1'b1;
    if (!is_first && arrived_m) begin
      r.lin     = '0;
      r.ang     = '0;
      r.arrived = 1'b1;
      return r;
    end

    lin = (longint'(lin_gain_m) * dist_v + (longint'(1) << (SPEED_SH - 1))) >>> SPEED_SH;
    if (lin > LIN_MAX) lin = LIN_MAX;
    if (lin < 0) lin = 0;
    // heading error is left unwrapped
    ang = (longint'(ang_gain_m) * (bearing - longint'(hd)) + (longint'(1) << (SPEED_SH - 1)))
          >>> SPEED_SH;
    if (ang > ANG_MAX) ang = ANG_MAX;
    if (ang < ANG_MIN) ang = ANG_MIN;
    r.lin     = LIN_W'(lin);
    r.ang     = ANG_W'(ang);
    r.arrived = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at command %0d: %s got %0d, expected %0d",
               cmds_checked, what, got, want);
  endtask

  // pose driver: the next request goes out once the slot is free
  always @(posedge clk) begin
    if (!rst_n) begin
      pose_bus.valid <= 1'b0;
    end else begin
      if (pose_bus.valid && pose_bus.ready) begin
        cmd_exp_q.push_back(predict_command(pose_bus.pose_x, pose_bus.pose_y,
                                            pose_bus.pose_heading));
        poses_sent++;
      end
      if (!pose_bus.valid || pose_bus.ready) begin
        // a drain request holds off until every command in flight has come back
        if (pose_q.size() != 0 && !(pose_q[0].drain && cmd_exp_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          next_pose = pose_q.pop_front();
          pose_bus.valid        <= 1'b1;
          pose_bus.pose_x       <= next_pose.x;
          pose_bus.pose_y       <= next_pose.y;
          pose_bus.pose_heading <= next_pose.heading;
        end else begin
          pose_bus.valid <= 1'b0;
        end
      end
    end
  end

  // command monitor: every accepted command against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.ready <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        if (cmd_exp_q.size() == 0) begin
          report_mismatch("command with no pose pending", cmd_bus.linear_speed, 0);
        end else begin
          want_cmd = cmd_exp_q.pop_front();
          if (cmd_bus.linear_speed !== want_cmd.lin)
            report_mismatch("linear_speed", cmd_bus.linear_speed, want_cmd.lin);
          if (cmd_bus.turn_rate !== want_cmd.ang)
            report_mismatch("turn_rate", longint'(cmd_bus.turn_rate),
                            longint'(want_cmd.ang));
          if (cmd_bus.arrived !== want_cmd.arrived)
            report_mismatch("arrived", cmd_bus.arrived, want_cmd.arrived);
        end
        if (cmd_bus.arrived === 1'b1) arrivals++;
        cmds_checked++;
      end
      cmd_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands outstanding", cycles, cmd_exp_q.size());
      $display("FAIL go_to_goal_p_controller");
      $finish;
    end
  end

  task automatic queue_pose(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic signed [HEAD_W-1:0] hd, input bit drain);
    pose_req_t pr;
    pr.x       = px;
    pr.y       = py;
    pr.heading = hd;
    pr.drain   = drain;
    pose_q.push_back(pr);
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_idle();
    @(negedge clk);
    while (pose_q.size() != 0 || pose_bus.valid || cmd_exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_GOAL_X:   goal_x_m   = data;
      REG_GOAL_Y:   goal_y_m   = data;
      REG_TOL:      tol_m      = data;
      REG_LIN_GAIN: lin_gain_m = data[GAIN_W-1:0];
      REG_ANG_GAIN: ang_gain_m = data[GAIN_W-1:0];
      default: ;  // spare indexes are dropped by the block
    endcase
  endtask

  // write every register, gains with junk in the unused upper bits, then the spare indexes
  task automatic apply_setting(input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy,
                               input logic [POS_W-1:0] tol, input logic [GAIN_W-1:0] lg,
                               input logic [GAIN_W-1:0] ag);
    wait_idle();
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_TOL, tol);
    write_reg(REG_LIN_GAIN, {4'($urandom), lg});
    write_reg(REG_ANG_GAIN, {4'($urandom), ag});
    for (int k = REG_ANG_GAIN + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default:   begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // stimulus sequencer
  initial begin
    logic [POS_W-1:0]         gx, gy, px, py, tol;
    logic [GAIN_W-1:0]        lg, ag;
    logic signed [HEAD_W-1:0] hd;
    int  sel, ux, uy, m, m_stop;
    real ulen;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pose_bus.valid = 1'b0;
    pose_bus.pose_x       = '0;
    pose_bus.pose_y       = '0;
    pose_bus.pose_heading = '0;
    cmd_bus.ready  = 1'b0;
    errors = 0;
    poses_sent = 0;
    cmds_checked = 0;
    arrivals = 0;
    settings_applied = 0;
    cycles = 0;
    set_idle(IDLE_NONE);

    // register defaults after reset
    goal_x_m     = 16'd4096;
    goal_y_m     = 16'd4096;
    tol_m        = 16'd41;
    lin_gain_m   = 12'd384;
    ang_gain_m   = 12'd1024;
    seen_first_m = 1'b0;
    arrived_m    = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first pose sits right on the default goal: still gets a command
    queue_pose(16'd4096, 16'd4096, 15'sd12868, 1'b0);

    // directed: zero tolerance so nothing arrives, geometry corners
    apply_setting(16'd4096, 16'd4096, 16'd0, 12'd384, 12'd1024);
    queue_pose(16'd8192, 16'd4096, 15'sd0, 1'b0);        // goal straight behind
    queue_pose(16'hFFFF, 16'd4096, -15'sd16384, 1'b0);   // behind, heading at its floor
    queue_pose(16'd0, 16'd4096, 15'sd16383, 1'b0);       // straight ahead, heading at its top
    queue_pose(16'd4096, 16'd0, 15'sd12868, 1'b0);
    queue_pose(16'd4096, 16'hFFFF, -15'sd12868, 1'b0);
    queue_pose(16'd0, 16'd0, 15'sd0, 1'b1);              // waits for an empty pipe
    queue_pose(16'hFFFF, 16'hFFFF, 15'sd0, 1'b0);
    queue_pose(16'd0, 16'hFFFF, 15'sd1, 1'b0);
    queue_pose(16'hFFFF, 16'd0, -15'sd1, 1'b0);
    queue_pose(16'd4097, 16'd4096, 15'sd0, 1'b0);        // one lsb off the goal
    queue_pose(16'd4096, 16'd4095, 15'sd0, 1'b0);
    queue_pose(16'd4095, 16'd4097, 15'sd0, 1'b0);

    // goal in the corner, full gains: linear speed saturates on the far poses
    apply_setting(16'd0, 16'd0, 16'd0, 12'hFFF, 12'hFFF);
    queue_pose(16'hFFFF, 16'hFFFF, -15'sd16384, 1'b0);
    queue_pose(16'hFFFF, 16'd0, -15'sd16384, 1'b0);
    queue_pose(16'd1, 16'd0, 15'sd16383, 1'b0);
    queue_pose(16'd0, 16'hFFFF, 15'sd0, 1'b0);

    // goal in the far corner, zero gains
    apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 12'd0, 12'd0);
    queue_pose(16'd0, 16'd0, 15'sd12868, 1'b0);
    queue_pose(16'hFFFF, 16'd0, -15'sd12868, 1'b0);

    // random phases, tolerance held at zero so every pose gets a real command
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1:       begin gx = '0; gy = '0; end
        2:       begin gx = '1; gy = '1; end
        default: begin
          gx = POS_W'($urandom_range(POS_LIM));
          gy = POS_W'($urandom_range(POS_LIM));
        end
      endcase
      lg = (p == 3) ? '0 : (p == 4) ? '1 : GAIN_W'($urandom_range(4095));
      ag = (p == 3) ? '0 : (p == 4) ? '1 : GAIN_W'($urandom_range(4095));
      apply_setting(gx, gy, '0, lg, ag);
      set_idle(idle_mode_t'(p % 4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          px = POS_W'($urandom_range(POS_LIM));
          py = POS_W'($urandom_range(POS_LIM));
        end else if (sel < 85) begin
          px = POS_W'($urandom);
          py = POS_W'($urandom);
        end else begin
          // close in on the goal, wrapping at the field edges
          px = gx + POS_W'($urandom_range(128)) - POS_W'(64);
          py = gy + POS_W'($urandom_range(128)) - POS_W'(64);
        end
        if (px == gx && py == gy) px = px ^ POS_W'(1);
        if ($urandom_range(9) < 7) hd = HEAD_W'(int'($urandom_range(2 * HEAD_LIM)) - HEAD_LIM);
        else hd = HEAD_W'($urandom);
        queue_pose(px, py, hd, $urandom_range(49) == 0);
      end
    end

    // approach run: walk straight in on the goal in small steps until past the tolerance
    gx  = POS_W'($urandom_range(36864, 8192));
    gy  = POS_W'($urandom_range(36864, 8192));
    tol = POS_W'($urandom_range(600, 100));
    apply_setting(gx, gy, tol, GAIN_W'($urandom_range(4095)), GAIN_W'($urandom_range(4095)));
    set_idle(IDLE_BOTH);
    do begin
      ux = int'($urandom_range(128)) - 64;
      uy = int'($urandom_range(128)) - 64;
    end while (ux * ux + uy * uy < 256);
    ulen   = $sqrt(real'(ux * ux + uy * uy));
    m_stop = int'(real'(tol) * 64.0 / ulen) - 100;
    m      = m_stop + 700;
    while (m > m_stop && m > 0) begin
      px = POS_W'(int'(gx) + (ux * m) / 64);
      py = POS_W'(int'(gy) + (uy * m) / 64);
      if ($urandom_range(9) < 8) hd = HEAD_W'(int'($urandom_range(2 * HEAD_LIM)) - HEAD_LIM);
      else hd = HEAD_W'($urandom);
      queue_pose(px, py, hd, 1'b0);
      m = m - int'($urandom_range(8, 1));
    end

    // registers rewritten after arrival, the latch must keep the command at zero
    apply_setting(POS_W'($urandom_range(POS_LIM)), POS_W'($urandom_range(POS_LIM)), '1,
                  '1, GAIN_W'($urandom_range(4095)));
    set_idle(IDLE_RECV);
    for (int n = 0; n < 20; n++)
      queue_pose(POS_W'($urandom), POS_W'($urandom), HEAD_W'($urandom), 1'b0);

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (cmd_exp_q.size() != 0)
      report_mismatch("commands never delivered", cmd_exp_q.size(), 0);

    $display("run covered %0d poses over %0d register settings, %0d commands checked",
             poses_sent, settings_applied, cmds_checked);
    $display("arrival seen on %0d commands, %0d mismatches", arrivals, errors);
    if (errors == 0) begin
      $display("PASS go_to_goal_p_controller");
    end else begin
      $display("FAIL go_to_goal_p_controller");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/g2g_pkg.sv
rtl/core/g2g_if.sv
rtl/core/go_to_goal_p_controller.sv
tb/go_to_goal_p_controller_tb.sv
